// ----- sv/encoder_timed_order_queues_unit_defines.svh -----
// assertion macros shared by the rtl files
`ifndef ENCODER_TIMED_ORDER_QUEUES_UNIT_DEFINES_SVH
`define ENCODER_TIMED_ORDER_QUEUES_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ETQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("etq check failed");
`define ETQ_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error("etq check failed");
`else
`define ETQ_ASSERT(label, clk, rst_n, prop)
`define ETQ_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ----- sv/etq_pkg.sv -----
package etq_pkg;
	localparam int MaxArms = 4;
	localparam int QueueDepth = 8;
	localparam int EncModulus = 100000;
	localparam int ArmW = $clog2(MaxArms);
	localparam int SlotW = $clog2(QueueDepth);
	localparam int FillW = $clog2(QueueDepth + 1);
	localparam int AddrW = ArmW + SlotW;
	localparam int EncW = 17;
	localparam int DistW = 24;
	localparam int PosW = 23;
	localparam int TgtW = 25;

	localparam logic [2:0] RegArmCount = 3'd0;

	typedef enum logic [2:0] {
		CmdNone,
		CmdStart,
		CmdRead,
		CmdWrite,
		CmdFinish,
		CmdEmit
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [ArmW-1:0] arm;
		logic [SlotW-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic is_add;
		logic scan_done;
		logic [ArmW-1:0] arms_last;
		logic [ArmW-1:0] add_arm;
	} status_t;

	typedef struct packed {
		logic signed [DistW-1:0] dval;
		logic side;
		logic act;
	} entry_t;
endpackage

// ----- sv/etq_ctrl.sv -----
module etq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_go,
	input etq_pkg::status_t st,
	input logic out_ready,
	output logic busy,
	output logic out_valid,
	output etq_pkg::cmd_t cmd
);
	import etq_pkg::*;
	`include "encoder_timed_order_queues_unit_defines.svh"

	typedef enum logic [2:0] {SIdle, SStart, SRead, SWrite, SNext, SEmit} state_t;
	state_t state_q;
	logic [ArmW-1:0] arm_q;
	logic [SlotW-1:0] slot_q;

	assign busy = (state_q != SIdle);
	assign out_valid = (state_q == SEmit);

	always_comb begin
		cmd.arm = arm_q;
		cmd.slot = slot_q;
		case (state_q)
			SIdle: cmd.op = in_go ? CmdStart : CmdNone;
			SRead: cmd.op = CmdRead;
			SWrite: cmd.op = CmdWrite;
			SNext: cmd.op = CmdFinish;
			SEmit: cmd.op = (out_ready) ? CmdEmit : CmdNone;
			default: cmd.op = CmdNone;
		endcase
	end

	// per arm: read/write each slot in order (one slot pass), then finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle;
			arm_q <= '0;
			slot_q <= '0;
		end else begin
			case (state_q)
				SIdle: if (in_go) begin
					state_q <= SStart;
				end
				SStart: begin
					arm_q <= st.is_add ? st.add_arm : '0;
					slot_q <= '0;
					state_q <= SRead;
				end
				SRead: state_q <= SWrite;
				SWrite: begin
					if (st.scan_done) state_q <= SNext;
					else begin
						slot_q <= slot_q + 1'b1;
						state_q <= SRead;
					end
				end
				SNext: begin
					slot_q <= '0;
					if (st.is_add || arm_q == st.arms_last) begin
						arm_q <= '0;
						state_q <= SEmit;
					end else begin
						arm_q <= arm_q + 1'b1;
						state_q <= SRead;
					end
				end
				SEmit: if (out_ready) begin
					if (arm_q == st.arms_last) state_q <= SIdle;
					else arm_q <= arm_q + 1'b1;
				end
				default: state_q <= SIdle;
			endcase
		end
	end

	`ETQ_ASSERT(a_go_idle, clk, arst_n, in_go |-> state_q == SIdle)
	`ETQ_ASSERT_NEXT(a_emit_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(arm_q))
	`ETQ_ASSERT(a_emit_range, clk, arst_n, out_valid |-> arm_q <= st.arms_last)
endmodule

// ----- sv/etq_datapath.sv -----
module etq_datapath (
	input logic clk,
	input logic arst_n,
	input etq_pkg::cmd_t cmd,
	output etq_pkg::status_t st,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [22:0] cfg_data,
	input logic kind,
	input logic [16:0] encoder_value,
	input logic signed [23:0] brick_position,
	input logic [3:0] pallet,
	input logic is_brick,
	output logic [1:0] arm_index,
	output logic [1:0] action,
	output logic side,
	output logic signed [24:0] target_value,
	output logic expired,
	output logic rejected,
	output logic last
);
	import etq_pkg::*;
	`include "encoder_timed_order_queues_unit_defines.svh"

	logic [2:0] arm_count_q;
	logic [PosW-1:0] arm_pos_q [MaxArms];
	logic [EncW-1:0] last_enc_q;
	logic [FillW-1:0] fill_q [MaxArms];
	logic [MaxArms-1:0] exp_q;
	logic rej_q;
	logic [ArmW-1:0] arms_last;

	// captured request
	logic kind_q;
	logic [EncW-1:0] enc_q;
	logic signed [DistW-1:0] bpos_q;
	logic [3:0] pallet_q;
	logic brick_q;
	logic [EncW:0] adv_q;
	logic signed [DistW-1:0] newd_q;
	logic [ArmW-1:0] add_arm_q;

	// queue memory, one row per arm
	entry_t mem_q [MaxArms*QueueDepth];
	entry_t head_q [MaxArms];
	entry_t rd_s1;
	entry_t carry_q;
	logic ins_done_q;
	logic dropped_q;

	always_comb begin
		if (arm_count_q == 3'd0) arms_last = '0;
		else if (arm_count_q > 3'(MaxArms)) arms_last = ArmW'(MaxArms - 1);
		else arms_last = ArmW'(arm_count_q - 3'd1);
	end

	logic [3:0] pm1;
	logic [EncW-1:0] enc_mod;
	logic valid_add;
	assign pm1 = pallet_q - 4'd1;
	assign add_arm_q = pm1[ArmW:1];
	assign valid_add = (pallet_q != 4'd0) && (pm1[3:1] <= {1'b0, arms_last})
		&& (fill_q[add_arm_q] < FillW'(QueueDepth));
	assign enc_mod = (enc_q >= EncW'(EncModulus)) ? enc_q - EncW'(EncModulus) : enc_q;

	assign st.is_add = kind_q;
	assign st.arms_last = arms_last;
	assign st.add_arm = add_arm_q;
	assign st.scan_done = (cmd.slot == SlotW'(QueueDepth - 1));

	logic [AddrW-1:0] addr;
	logic [AddrW-1:0] waddr;
	assign addr = {cmd.arm, cmd.slot};
	// after a dropped head every later entry moves down one slot
	assign waddr = (!kind_q && dropped_q && cmd.slot != '0) ? addr - 1'b1 : addr;

	// aged value of the read entry
	logic signed [DistW+1:0] aged_w;
	logic signed [DistW-1:0] aged;
	assign aged_w = {{2{rd_s1.dval[DistW-1]}}, rd_s1.dval} - $signed({1'b0, adv_q});
	assign aged = (aged_w < -(26'sd1 <<< (DistW-1))) ? {1'b1, {(DistW-1){1'b0}}} : aged_w[DistW-1:0];

	logic [FillW-1:0] fcur;
	logic in_q;
	logic drop_w;
	assign fcur = fill_q[cmd.arm];
	assign in_q = ({1'b0, cmd.slot} < fcur);
	assign drop_w = !kind_q && (cmd.slot == '0) && in_q && (aged <= 0);

	entry_t wr;
	logic wr_en;
	entry_t newe;
	assign newe = '{dval: newd_q, side: pallet_q[0], act: brick_q};

	always_comb begin
		wr = rd_s1;
		wr_en = 1'b0;
		if (kind_q) begin
			// insertion by shifting a carried entry through the row
			if (!ins_done_q) begin
				if (!in_q) begin
					wr = newe; wr_en = !rej_q && ({1'b0, cmd.slot} == fcur);
				end else if (rd_s1.dval > newd_q) begin
					wr = newe; wr_en = !rej_q;
				end
			end else if ({1'b0, cmd.slot} <= fcur) begin
				wr = carry_q; wr_en = !rej_q;
			end
		end else begin
			wr.dval = aged;
			wr_en = in_q;
		end
	end

	logic [EncW:0] adv_w;
	assign adv_w = (enc_mod >= last_enc_q) ? {1'b0, enc_mod - last_enc_q}
		: (EncW+1)'(EncModulus) + enc_mod - last_enc_q;

	logic signed [DistW+1:0] nd_w;
	assign nd_w = $signed({3'b0, arm_pos_q[add_arm_q]}) - {{2{bpos_q[DistW-1]}}, bpos_q};

	always_ff @(posedge clk) begin
		rd_s1 <= mem_q[addr];
		if (cmd.op == CmdStart) begin
			kind_q <= kind; enc_q <= encoder_value; bpos_q <= brick_position;
			pallet_q <= pallet; brick_q <= is_brick;
		end
		if (wr_en && cmd.op == CmdWrite) mem_q[waddr] <= wr;
		if (cmd.op == CmdWrite && kind_q && wr_en && !ins_done_q) carry_q <= rd_s1;
		else if (cmd.op == CmdWrite && kind_q && ins_done_q) carry_q <= rd_s1;
		if (cmd.op == CmdWrite && (cmd.slot == '0
			|| (!kind_q && dropped_q && cmd.slot == SlotW'(1))))
			head_q[cmd.arm] <= wr_en ? wr : rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_count_q <= 3'd4;
			for (int i = 0; i < MaxArms; i++) begin
				arm_pos_q[i] <= '0;
				fill_q[i] <= '0;
			end
			last_enc_q <= '0;
			exp_q <= '0;
			rej_q <= 1'b0;
			adv_q <= '0;
			newd_q <= '0;
			ins_done_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegArmCount) arm_count_q <= cfg_data[2:0];
				else if (cfg_index <= 3'(MaxArms))
					arm_pos_q[ArmW'(cfg_index - 3'd1)] <= cfg_data;
			end
			case (cmd.op)
				CmdStart: begin
					exp_q <= '0;
					ins_done_q <= 1'b0;
					dropped_q <= 1'b0;
				end
				CmdRead: if (cmd.slot == '0) begin
					if (!kind_q) begin
						// advance is taken once, before the first arm moves last_enc_q
						if (cmd.arm == '0) adv_q <= adv_w;
						rej_q <= 1'b0;
					end else begin
						rej_q <= !valid_add;
						newd_q <= (nd_w > 26'sd8388607) ? 24'sh7fffff : nd_w[DistW-1:0];
					end
				end
				CmdWrite: begin
					if (kind_q && wr_en && !ins_done_q) ins_done_q <= 1'b1;
					if (cmd.slot == '0) dropped_q <= drop_w;
				end
				CmdFinish: begin
					if (!kind_q) begin
						last_enc_q <= enc_mod;
						if (dropped_q) begin
							exp_q[cmd.arm] <= 1'b1;
							fill_q[cmd.arm] <= fill_q[cmd.arm] - 1'b1;
						end
					end else if (!rej_q) fill_q[cmd.arm] <= fill_q[cmd.arm] + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// head of the arm being reported
	logic signed [TgtW-1:0] tgt;
	entry_t h;
	assign h = head_q[cmd.arm];
	assign tgt = $signed({{(TgtW-EncW){1'b0}}, last_enc_q}) + TgtW'(h.dval);
	assign arm_index = cmd.arm;
	assign action = (fill_q[cmd.arm] != '0) ? (h.act ? 2'd2 : 2'd1) : 2'd0;
	assign side = (fill_q[cmd.arm] != '0) ? h.side : 1'b0;
	assign target_value = (fill_q[cmd.arm] != '0) ? tgt : '0;
	assign expired = exp_q[cmd.arm];
	assign rejected = rej_q;
	assign last = (cmd.arm == arms_last);

	`ETQ_ASSERT(a_fill_max, clk, arst_n, fill_q[0] <= FillW'(QueueDepth))
	`ETQ_ASSERT(a_exp_tick, clk, arst_n, kind_q && cmd.op == CmdEmit |-> !expired)
	`ETQ_ASSERT(a_rej_add, clk, arst_n, !kind_q && cmd.op == CmdEmit |-> !rejected)
endmodule

// ----- sv/encoder_timed_order_queues_unit.sv -----
// channel | direction | handshake
// in      | into unit | in_valid / in_ready
// out     | from unit | out_valid / out_ready, one result per arm in use
// cfg     | into unit | cfg_valid / cfg_ready, register index and data
// an item passes a start state, then for each arm walked a read then a write
// per slot and a finish state; a tick walks every arm in use, an add walks
// only its own arm; then each result is delivered as out_ready takes it
// reset clears control, fill counts and arm positions and sets the arm count to 4; queue memory is not cleared
// the next item is taken only after the last result is taken
module encoder_timed_order_queues_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [16:0] encoder_value,
	input logic signed [23:0] brick_position,
	input logic [3:0] pallet,
	input logic is_brick,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] arm_index,
	output logic [1:0] action,
	output logic side,
	output logic signed [24:0] target_value,
	output logic expired,
	output logic rejected,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [22:0] cfg_data
);
	import etq_pkg::*;

	cmd_t cmd;
	status_t st;
	logic busy;

	assign in_ready = !busy;
	assign cfg_ready = 1'b1;

	etq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_valid && !busy), .st(st),
		.out_ready(out_ready), .busy(busy), .out_valid(out_valid), .cmd(cmd)
	);

	etq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.kind(kind), .encoder_value(encoder_value), .brick_position(brick_position),
		.pallet(pallet), .is_brick(is_brick), .arm_index(arm_index), .action(action),
		.side(side), .target_value(target_value), .expired(expired),
		.rejected(rejected), .last(last)
	);
endmodule
